@@ hdl/fdpp_pkg.sv @@
// Shared types, constants and helpers for the four-D point projector.
// No dependencies; the xform, divider, screen and top-level files import this package.
package fdpp_pkg;

  localparam int CoefW      = 32;
  localparam int VecLen     = 4;
  localparam int StoreDepth = 40;
  localparam int ROT4_BASE  = 0;
  localparam int ROT3_BASE  = 16;
  localparam int CAM4_BASE  = 32;
  localparam int CAM3_BASE  = 36;

  // divider geometry: numerator is a Q16.16 lane times at most 2^17
  localparam int NumW  = 50;
  localparam int MagW  = 49;
  localparam int QuotW = 32;

  localparam logic [11:0]        HalfWidthRst  = 12'd1250;
  localparam logic [11:0]        HalfHeightRst = 12'd600;
  localparam logic signed [15:0] AspectRst     = -16'sd7282;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_POINT = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    REG_HALF_WIDTH  = 2'd0,
    REG_HALF_HEIGHT = 2'd1,
    REG_ASPECT      = 2'd2
  } reg_idx_t;

  typedef logic signed [CoefW-1:0] q16_t;
  typedef logic signed [NumW-1:0]  num_t;

  // sideband that travels with every item
  typedef struct packed {
    logic        point;  // point item
    logic        live;   // point not culled so far
    logic        load;   // in-range coefficient load
    logic [5:0]  idx;
    logic [31:0] val;
  } tag_t;

  localparam logic signed [65:0] SatMax = 66'sd2147483647;
  localparam logic signed [65:0] SatMin = -SatMax - 66'sd1;

  function automatic q16_t sat32(input logic signed [65:0] v);
    if (v > SatMax) begin
      return 32'sh7fffffff;
    end else if (v < SatMin) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // a * 2 * 65536
  function automatic num_t scale_w(input q16_t a);
    return {{(NumW-CoefW-17){a[CoefW-1]}}, a, 17'b0};
  endfunction

  // a * 3 * 32768
  function automatic num_t scale_z(input q16_t a);
    num_t ext;
    ext = NumW'(a);
    return (ext <<< 16) + (ext <<< 15);
  endfunction

endpackage

@@ hdl/fdpp_if.sv @@
// Valid/ready channel interfaces: point/load items in, screen results out.
// No dependencies.
interface fdpp_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [5:0]  coef_index;
  logic [31:0] coef_value;
  logic [31:0] point_x;
  logic [31:0] point_y;
  logic [31:0] point_z;
  logic [31:0] point_w;

  modport source (output valid, op, coef_index, coef_value, point_x, point_y, point_z,
                  point_w, input ready);
  modport sink (input valid, op, coef_index, coef_value, point_x, point_y, point_z,
                point_w, output ready);
endinterface

interface fdpp_out_if;
  logic        valid;
  logic        ready;
  logic        visible;
  logic [31:0] screen_x;
  logic [31:0] screen_y;
  logic [31:0] depth;

  modport source (output valid, visible, screen_x, screen_y, depth, input ready);
  modport sink (input valid, visible, screen_x, screen_y, depth, output ready);
endinterface

@@ hdl/fdpp_xform.sv @@
// Camera subtract and row-vector times 4x4 matrix, four register stages.
// Holds its own camera and matrix coefficients; depends on fdpp_pkg.
module fdpp_xform #(
  parameter int ROT_BASE = fdpp_pkg::ROT4_BASE,
  parameter int CAM_BASE = fdpp_pkg::CAM4_BASE
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  fdpp_pkg::tag_t  in_tag,
  input  fdpp_pkg::q16_t  in_vec [fdpp_pkg::VecLen],
  output logic            out_vld,
  output fdpp_pkg::tag_t  out_tag,
  output fdpp_pkg::q16_t  out_vec [fdpp_pkg::VecLen]
);
  import fdpp_pkg::*;

  q16_t cam [VecLen];
  q16_t rot [VecLen*VecLen];

  logic s1_vld, s2_vld, s3_vld;
  tag_t s1_tag, s2_tag, s3_tag;
  q16_t s1_vec [VecLen];
  logic signed [63:0] s2_prod [VecLen*VecLen];
  logic signed [64:0] s3_sum [2*VecLen];
  logic signed [65:0] lane_sum [VecLen];
  q16_t lane_res [VecLen];

  logic [5:0] cam_off, rot_off;
  logic       cam_hit, rot_hit;

  assign cam_off = in_tag.idx - 6'(CAM_BASE);
  assign rot_off = s1_tag.idx - 6'(ROT_BASE);
  assign cam_hit = en && in_vld && in_tag.load &&
                   in_tag.idx >= 6'(CAM_BASE) && in_tag.idx < 6'(CAM_BASE + VecLen);
  assign rot_hit = en && s1_vld && s1_tag.load &&
                   s1_tag.idx >= 6'(ROT_BASE) && s1_tag.idx < 6'(ROT_BASE + VecLen*VecLen);

  // coefficients change as the load item passes the stage that reads them
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VecLen; i++) cam[i] <= '0;
      for (int i = 0; i < VecLen*VecLen; i++) rot[i] <= '0;
    end else begin
      if (cam_hit) cam[cam_off[1:0]] <= in_tag.val;
      if (rot_hit) rot[rot_off[3:0]] <= s1_tag.val;
    end
  end

  always_comb begin
    for (int c = 0; c < VecLen; c++) begin
      lane_sum[c] = 66'(s3_sum[2*c]) + 66'(s3_sum[2*c+1]);
      lane_res[c] = sat32(lane_sum[c] >>> 16);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld  <= 1'b0;
      s2_vld  <= 1'b0;
      s3_vld  <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      s1_vld  <= in_vld;
      s2_vld  <= s1_vld;
      s3_vld  <= s2_vld;
      out_vld <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_tag  <= in_tag;
      s2_tag  <= s1_tag;
      s3_tag  <= s2_tag;
      out_tag <= s3_tag;
      for (int i = 0; i < VecLen; i++) begin
        s1_vec[i] <= sat32(66'(in_vec[i]) - 66'(cam[i]));
      end
      for (int r = 0; r < VecLen; r++) begin
        for (int c = 0; c < VecLen; c++) begin
          s2_prod[r*VecLen+c] <= 64'(s1_vec[r]) * 64'(rot[r*VecLen+c]);
        end
      end
      for (int c = 0; c < VecLen; c++) begin
        s3_sum[2*c]   <= 65'(s2_prod[c]) + 65'(s2_prod[VecLen+c]);
        s3_sum[2*c+1] <= 65'(s2_prod[2*VecLen+c]) + 65'(s2_prod[3*VecLen+c]);
      end
      for (int c = 0; c < VecLen; c++) out_vec[c] <= lane_res[c];
    end
  end

endmodule

@@ hdl/fdpp_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, shared divisor.
// Culls on divisor <= 0, truncates toward zero, saturates; depends on fdpp_pkg.
module fdpp_div #(
  parameter int LANES = 3
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  fdpp_pkg::tag_t  in_tag,
  input  fdpp_pkg::num_t  in_num [LANES],
  input  fdpp_pkg::q16_t  in_den,
  output logic            out_vld,
  output fdpp_pkg::tag_t  out_tag,
  output fdpp_pkg::q16_t  out_quo [LANES],
  output fdpp_pkg::q16_t  out_den
);
  import fdpp_pkg::*;

  // entry stage
  logic e_vld;
  tag_t e_tag;
  num_t e_num [LANES];
  q16_t e_den;
  tag_t cull_tag;

  // index 0 is the sign/overflow stage, 1..QuotW the bit steps
  logic              st_vld [QuotW+1];
  tag_t              st_tag [QuotW+1];
  q16_t              st_den [QuotW+1];
  logic              st_neg [QuotW+1][LANES];
  logic              st_ovf [QuotW+1][LANES];
  logic [QuotW-1:0]  st_rem [QuotW+1][LANES];
  logic [QuotW-1:0]  st_low [QuotW+1][LANES];
  logic [QuotW-1:0]  st_quo [QuotW+1][LANES];

  logic [MagW-1:0]   mag [LANES];
  logic [QuotW:0]    trial [QuotW+1][LANES];
  logic              take [QuotW+1][LANES];
  logic signed [33:0] signed_quo [LANES];

  always_comb begin
    cull_tag      = in_tag;
    cull_tag.live = in_tag.live && (in_den > 32'sd0);
    for (int l = 0; l < LANES; l++) begin
      mag[l] = e_num[l][NumW-1] ? MagW'(-e_num[l]) : MagW'(e_num[l]);
    end
    for (int k = 0; k <= QuotW; k++) begin
      for (int l = 0; l < LANES; l++) begin
        trial[k][l] = '0;
        take[k][l]  = 1'b0;
      end
    end
    for (int k = 1; k <= QuotW; k++) begin
      for (int l = 0; l < LANES; l++) begin
        trial[k][l] = {st_rem[k-1][l], st_low[k-1][l][QuotW-k]};
        take[k][l]  = trial[k][l] >= {1'b0, st_den[k-1]};
      end
    end
    for (int l = 0; l < LANES; l++) begin
      signed_quo[l] = st_neg[QuotW][l] ? -$signed({2'b0, st_quo[QuotW][l]})
                                       : $signed({2'b0, st_quo[QuotW][l]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld   <= 1'b0;
      out_vld <= 1'b0;
      for (int k = 0; k <= QuotW; k++) st_vld[k] <= 1'b0;
    end else if (en) begin
      e_vld     <= in_vld;
      st_vld[0] <= e_vld;
      for (int k = 1; k <= QuotW; k++) st_vld[k] <= st_vld[k-1];
      out_vld   <= st_vld[QuotW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_tag      <= cull_tag;
      e_den      <= in_den;
      for (int l = 0; l < LANES; l++) e_num[l] <= in_num[l];

      st_tag[0] <= e_tag;
      st_den[0] <= e_den;
      for (int l = 0; l < LANES; l++) begin
        st_neg[0][l] <= e_num[l][NumW-1];
        // quotient of 2^32 or more saturates whatever the sign
        st_ovf[0][l] <= QuotW'(mag[l][MagW-1:QuotW]) >= e_den;
        st_rem[0][l] <= QuotW'(mag[l][MagW-1:QuotW]);
        st_low[0][l] <= mag[l][QuotW-1:0];
        st_quo[0][l] <= '0;
      end

      for (int k = 1; k <= QuotW; k++) begin
        st_tag[k] <= st_tag[k-1];
        st_den[k] <= st_den[k-1];
        for (int l = 0; l < LANES; l++) begin
          st_neg[k][l] <= st_neg[k-1][l];
          st_ovf[k][l] <= st_ovf[k-1][l];
          st_low[k][l] <= st_low[k-1][l];
          st_rem[k][l] <= take[k][l] ? QuotW'(trial[k][l] - {1'b0, st_den[k-1]})
                                     : trial[k][l][QuotW-1:0];
          st_quo[k][l] <= {st_quo[k-1][l][QuotW-2:0], take[k][l]};
        end
      end

      out_tag <= st_tag[QuotW];
      out_den <= st_den[QuotW];
      for (int l = 0; l < LANES; l++) begin
        if (st_ovf[QuotW][l]) begin
          out_quo[l] <= st_neg[QuotW][l] ? 32'sh80000000 : 32'sh7fffffff;
        end else begin
          out_quo[l] <= sat32(66'(signed_quo[l]));
        end
      end
    end
  end

endmodule

@@ hdl/fdpp_screen.sv @@
// Pixel mapping: scale by half width/height and aspect, add screen center.
// Three register stages, last one is the result register; depends on fdpp_pkg.
module fdpp_screen (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_vld,
  input  logic                in_live,
  input  fdpp_pkg::q16_t      in_px,
  input  fdpp_pkg::q16_t      in_py,
  input  fdpp_pkg::q16_t      in_depth,
  input  logic [11:0]         half_width,
  input  logic [11:0]         half_height,
  input  logic signed [15:0]  aspect_ratio,
  output logic                out_vld,
  output logic                out_visible,
  output fdpp_pkg::q16_t      out_x,
  output fdpp_pkg::q16_t      out_y,
  output fdpp_pkg::q16_t      out_depth
);
  import fdpp_pkg::*;

  logic a_vld, b_vld;
  logic a_live, b_live;
  q16_t a_depth, b_depth;
  logic signed [44:0] a_mx, a_my;
  q16_t b_sx;
  logic signed [60:0] b_ty;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld   <= 1'b0;
      b_vld   <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      a_vld   <= in_vld;
      b_vld   <= a_vld;
      out_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_live  <= in_live;
      a_depth <= in_depth;
      a_mx    <= 45'(in_px) * 45'($signed({1'b0, half_width}));
      a_my    <= 45'(in_py) * 45'($signed({1'b0, half_height}));

      b_live  <= a_live;
      b_depth <= a_depth;
      b_sx    <= sat32(66'(a_mx) + 66'($signed({1'b0, half_width, 16'b0})));
      b_ty    <= 61'(a_my) * 61'(aspect_ratio);

      out_visible <= b_live;
      out_x       <= b_live ? b_sx : '0;
      out_y       <= b_live ? sat32(66'(b_ty >>> 12) +
                                    66'($signed({1'b0, half_height, 16'b0}))) : '0;
      out_depth   <= b_live ? b_depth : '0;
    end
  end

endmodule

@@ hdl/four_d_point_projector.sv @@
// Top level of the four-D point projector: APB registers, input tagging and
// the stage chain xform4 -> div -> xform3 -> div -> screen. Uses fdpp_pkg and fdpp_if.
//
// Usage
//   vertex channel: one item per handshake. op=0 loads coef_index/coef_value
//   (0-15 rot4, 16-31 rot3, 32-35 cam4, 36-39 cam3; higher indexes ignored),
//   op=1 projects point_x..point_w. Every item yields exactly one pixel item;
//   loads and culled points come out with visible=0 and zero fields.
//   Loads take effect for every later item, even while earlier points are
//   still in flight: each coefficient group sits at the stage that reads it
//   and is updated as the load passes.
//   APB: half_width at 0x0, half_height at 0x4, aspect_ratio at 0x8; write only
//   while no items are in flight.
// Timing
//   Items pass the 4D matrix stage, a divider (entry, sign/overflow, one
//   quotient bit per stage over 32 bits, output), the 3D matrix stage, a
//   divider and pixel mapping. One item per cycle unless pixel.ready stalls;
//   the divider bit chain sets the depth, the 32x32 multipliers the clock.
// Reset and stall
//   rst clears the pipeline valids, the coefficient store and the registers
//   to their defaults. When pixel.ready is low with a result waiting, the whole
//   pipeline holds and vertex.ready drops; nothing is lost or repeated.
module four_d_point_projector (
  input  logic        clk,
  input  logic        rst,
  fdpp_in_if.sink     vertex,
  fdpp_out_if.source  pixel,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fdpp_pkg::*;

  logic [11:0]        half_width;
  logic [11:0]        half_height;
  logic signed [15:0] aspect_ratio;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_width   <= HalfWidthRst;
      half_height  <= HalfHeightRst;
      aspect_ratio <= AspectRst;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_HALF_WIDTH:  half_width   <= pwdata[11:0];
        REG_HALF_HEIGHT: half_height  <= pwdata[11:0];
        REG_ASPECT:      aspect_ratio <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_HALF_WIDTH:  prdata = {20'b0, half_width};
      REG_HALF_HEIGHT: prdata = {20'b0, half_height};
      REG_ASPECT:      prdata = {{16{aspect_ratio[15]}}, aspect_ratio};
      default:         prdata = '0;
    endcase
  end

  // global advance: the result register is free or being taken
  logic en;
  assign en           = !pixel.valid || pixel.ready;
  assign vertex.ready = en;

  tag_t in_tag;
  q16_t in_vec [VecLen];

  always_comb begin
    in_tag.point = vertex.op == OP_POINT;
    in_tag.live  = vertex.op == OP_POINT;
    in_tag.load  = vertex.op == OP_LOAD && vertex.coef_index < 6'(StoreDepth);
    in_tag.idx   = vertex.coef_index;
    in_tag.val   = vertex.coef_value;
    in_vec[0]    = vertex.point_x;
    in_vec[1]    = vertex.point_y;
    in_vec[2]    = vertex.point_z;
    in_vec[3]    = vertex.point_w;
  end

  // 4D transform
  logic x4_vld;
  tag_t x4_tag;
  q16_t x4_vec [VecLen];

  fdpp_xform #(.ROT_BASE(ROT4_BASE), .CAM_BASE(CAM4_BASE)) u_xform4 (
    .clk, .rst, .en,
    .in_vld(vertex.valid), .in_tag(in_tag), .in_vec(in_vec),
    .out_vld(x4_vld), .out_tag(x4_tag), .out_vec(x4_vec)
  );

  // divide x, y, z by w (scale 2)
  num_t da_num [3];
  logic da_vld;
  tag_t da_tag;
  q16_t da_quo [3];
  q16_t da_den;

  always_comb begin
    for (int l = 0; l < 3; l++) da_num[l] = scale_w(x4_vec[l]);
  end

  fdpp_div #(.LANES(3)) u_div4 (
    .clk, .rst, .en,
    .in_vld(x4_vld), .in_tag(x4_tag), .in_num(da_num), .in_den(x4_vec[3]),
    .out_vld(da_vld), .out_tag(da_tag), .out_quo(da_quo), .out_den(da_den)
  );

  // 3D transform, w lane rides along
  q16_t p3_vec [VecLen];
  logic x3_vld;
  tag_t x3_tag;
  q16_t x3_vec [VecLen];

  always_comb begin
    for (int l = 0; l < 3; l++) p3_vec[l] = da_quo[l];
    p3_vec[3] = da_den;
  end

  fdpp_xform #(.ROT_BASE(ROT3_BASE), .CAM_BASE(CAM3_BASE)) u_xform3 (
    .clk, .rst, .en,
    .in_vld(da_vld), .in_tag(da_tag), .in_vec(p3_vec),
    .out_vld(x3_vld), .out_tag(x3_tag), .out_vec(x3_vec)
  );

  // divide x, y by z (scale 1.5)
  num_t db_num [2];
  logic db_vld;
  tag_t db_tag;
  q16_t db_quo [2];
  q16_t db_den;

  always_comb begin
    for (int l = 0; l < 2; l++) db_num[l] = scale_z(x3_vec[l]);
  end

  fdpp_div #(.LANES(2)) u_div3 (
    .clk, .rst, .en,
    .in_vld(x3_vld), .in_tag(x3_tag), .in_num(db_num), .in_den(x3_vec[2]),
    .out_vld(db_vld), .out_tag(db_tag), .out_quo(db_quo), .out_den(db_den)
  );

  fdpp_screen u_screen (
    .clk, .rst, .en,
    .in_vld(db_vld), .in_live(db_tag.point && db_tag.live),
    .in_px(db_quo[0]), .in_py(db_quo[1]), .in_depth(db_den),
    .half_width, .half_height, .aspect_ratio,
    .out_vld(pixel.valid), .out_visible(pixel.visible),
    .out_x(pixel.screen_x), .out_y(pixel.screen_y), .out_depth(pixel.depth)
  );

endmodule

@@ hdl/fdpp_checker.sv @@
// Port-level checks for the four-D point projector, bound to the top level.
// Depends only on the top level's ports.
module fdpp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        visible,
  input logic [31:0] screen_x,
  input logic [31:0] screen_y,
  input logic [31:0] depth
);

  // a waiting result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(visible) && $stable(screen_x) &&
                                $stable(screen_y) && $stable(depth))
    else $error("result changed while stalled");

  // hidden items carry zero fields
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !visible |-> screen_x == 32'd0 && screen_y == 32'd0 && depth == 32'd0)
    else $error("hidden item with nonzero fields");

  // visible points passed the z cull
  a_depth: assert property (@(posedge clk) disable iff (rst)
    out_valid && visible |-> $signed(depth) > 32'sd0)
    else $error("visible point with nonpositive depth");

  // input side advances exactly when the result register can
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready out of step with output");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind four_d_point_projector fdpp_checker u_fdpp_checker (
  .clk(clk),
  .rst(rst),
  .in_ready(vertex.ready),
  .out_valid(pixel.valid),
  .out_ready(pixel.ready),
  .visible(pixel.visible),
  .screen_x(pixel.screen_x),
  .screen_y(pixel.screen_y),
  .depth(pixel.depth)
);
